// ----- design/jts_pkg.sv -----
// ----------------------------------------------------------------------------
// jts_pkg
// Types, codes and character tables shared by the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int Q_DEPTH     = 4;
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef enum logic [3:0] {
        K_EOF      = 4'd0,
        K_LBRACE   = 4'd1,
        K_RBRACE   = 4'd2,
        K_LBRACKET = 4'd3,
        K_RBRACKET = 4'd4,
        K_COMMA    = 4'd5,
        K_COLON    = 4'd6,
        K_STRING   = 4'd7,
        K_NUMBER   = 4'd8,
        K_TRUE     = 4'd9,
        K_FALSE    = 4'd10,
        K_NULL     = 4'd11,
        K_ERROR    = 4'd12
    } t_kind;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_INT  = 3'd3,
        MODE_DOT  = 3'd4,
        MODE_FRAC = 3'd5,
        MODE_LIT  = 3'd6
    } t_mode;

    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FF       = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;
    localparam logic [7:0] CH_R        = 8'h72;
    localparam logic [7:0] CH_U        = 8'h75;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_L        = 8'h6C;
    localparam logic [7:0] CH_S        = 8'h73;

    typedef struct packed {
        t_mode                  mode;
        logic [1:0]             lit_which;
        logic [2:0]             lit_pos;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] count;
        logic                   finished;
        logic [OFFSET_BITS-1:0] cursor;
    } t_state;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:      MODE_IDLE,
        lit_which: 2'd0,
        lit_pos:   3'd0,
        start:     '0,
        count:     '0,
        finished:  1'b0,
        cursor:    '0
    };

    // remaining bytes of each literal after its first byte
    function automatic logic [2:0] lit_len(input logic [1:0] which);
        logic [2:0] len;
        case (which)
            LIT_TRUE:  len = 3'd3;
            LIT_FALSE: len = 3'd4;
            LIT_NULL:  len = 3'd3;
            default:   len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (which)
            LIT_TRUE: begin
                case (idx)
                    2'd0:    ch = CH_R;
                    2'd1:    ch = CH_U;
                    2'd2:    ch = CH_E;
                    default: ch = 8'h00;
                endcase
            end
            LIT_FALSE: begin
                case (idx)
                    2'd0:    ch = CH_A;
                    2'd1:    ch = CH_L;
                    2'd2:    ch = CH_S;
                    default: ch = CH_E;
                endcase
            end
            LIT_NULL: begin
                case (idx)
                    2'd0:    ch = CH_U;
                    2'd1:    ch = CH_L;
                    2'd2:    ch = CH_L;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_kind lit_kind(input logic [1:0] which);
        t_kind k;
        case (which)
            LIT_TRUE:  k = K_TRUE;
            LIT_FALSE: k = K_FALSE;
            LIT_NULL:  k = K_NULL;
            default:   k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

// ----- design/jts_step.sv -----
// ----------------------------------------------------------------------------
// jts_step
// Next-state and token logic for one input word; up to two tokens out.
// ----------------------------------------------------------------------------
module jts_step (
    input  jts_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_eoi,
    output jts_pkg::t_state  o_state,
    output jts_pkg::t_result o_res0,
    output jts_pkg::t_result o_res1,
    output logic [1:0]       o_res_cnt
);
    import jts_pkg::*;

    t_state                 s;
    logic                   fin_v;
    t_kind                  fin_k;
    logic [LENGTH_BITS-1:0] fin_len;
    logic                   idle_call;
    logic                   id_v;
    t_kind                  id_k;
    logic                   eof_v;
    logic [LENGTH_BITS-1:0] inc;
    logic                   is_dig;
    logic                   lit_hit;
    logic [2:0]             p_next;
    t_result                r_fin;
    t_result                r_id;
    t_result                r_eof;

    always_comb begin
        s         = i_state;
        fin_v     = 1'b0;
        fin_k     = K_ERROR;
        fin_len   = i_state.count;
        idle_call = 1'b0;
        id_v      = 1'b0;
        id_k      = K_ERROR;
        eof_v     = 1'b0;
        p_next    = i_state.lit_pos + 3'd1;
        inc       = (i_state.count == '1) ? i_state.count
                                          : i_state.count + LENGTH_BITS'(1);
        is_dig    = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        lit_hit   = (i_state.lit_pos < lit_len(i_state.lit_which)) &&
                    (i_byte == lit_char(i_state.lit_which, i_state.lit_pos[1:0]));

        if (i_state.finished) begin
            eof_v = 1'b1;
        end else if (i_eoi) begin
            case (i_state.mode)
                MODE_IDLE: ;
                MODE_INT, MODE_FRAC: begin
                    fin_v = 1'b1;
                    fin_k = K_NUMBER;
                end
                default: begin
                    fin_v = 1'b1;
                    fin_k = K_ERROR;
                end
            endcase
            if (fin_v) begin
                s.count = '0;
            end
            s.mode     = MODE_IDLE;
            s.finished = 1'b1;
            eof_v      = 1'b1;
        end else begin
            case (i_state.mode)
                MODE_STR: begin
                    s.count = inc;
                    if (i_byte == CH_QUOTE) begin
                        fin_v   = 1'b1;
                        fin_k   = K_STRING;
                        fin_len = inc;
                    end else if (i_byte == CH_BSLASH) begin
                        s.mode = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    s.count = inc;
                    s.mode  = MODE_STR;
                end
                MODE_INT: begin
                    if (is_dig) begin
                        s.count = inc;
                    end else if (i_byte == CH_DOT) begin
                        s.count = inc;
                        s.mode  = MODE_DOT;
                    end else begin
                        fin_v     = 1'b1;
                        fin_k     = K_NUMBER;
                        idle_call = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (is_dig) begin
                        s.count = inc;
                        s.mode  = MODE_FRAC;
                    end else begin
                        fin_v     = 1'b1;
                        fin_k     = K_ERROR;
                        idle_call = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_dig) begin
                        s.count = inc;
                    end else begin
                        fin_v     = 1'b1;
                        fin_k     = K_NUMBER;
                        idle_call = 1'b1;
                    end
                end
                MODE_LIT: begin
                    s.count = inc;
                    if (lit_hit) begin
                        s.lit_pos = p_next;
                        if (p_next >= lit_len(i_state.lit_which)) begin
                            fin_v   = 1'b1;
                            fin_k   = lit_kind(i_state.lit_which);
                            fin_len = inc;
                        end
                    end else begin
                        fin_v   = 1'b1;
                        fin_k   = K_ERROR;
                        fin_len = inc;
                    end
                end
                default: begin
                    s.mode    = MODE_IDLE;
                    idle_call = 1'b1;
                end
            endcase
            if (fin_v) begin
                s.mode  = MODE_IDLE;
                s.count = '0;
            end
            s.cursor = i_state.cursor + OFFSET_BITS'(1);

            if (idle_call) begin
                case (i_byte)
                    CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: ;
                    CH_LBRACE: begin
                        id_v = 1'b1;
                        id_k = K_LBRACE;
                    end
                    CH_RBRACE: begin
                        id_v = 1'b1;
                        id_k = K_RBRACE;
                    end
                    CH_LBRACKET: begin
                        id_v = 1'b1;
                        id_k = K_LBRACKET;
                    end
                    CH_RBRACKET: begin
                        id_v = 1'b1;
                        id_k = K_RBRACKET;
                    end
                    CH_COMMA: begin
                        id_v = 1'b1;
                        id_k = K_COMMA;
                    end
                    CH_COLON: begin
                        id_v = 1'b1;
                        id_k = K_COLON;
                    end
                    CH_QUOTE: begin
                        s.mode  = MODE_STR;
                        s.start = i_state.cursor;
                        s.count = LENGTH_BITS'(1);
                    end
                    CH_T, CH_F, CH_N: begin
                        s.mode    = MODE_LIT;
                        s.start   = i_state.cursor;
                        s.count   = LENGTH_BITS'(1);
                        s.lit_pos = 3'd0;
                        s.lit_which = (i_byte == CH_T) ? LIT_TRUE :
                                      (i_byte == CH_F) ? LIT_FALSE : LIT_NULL;
                    end
                    default: begin
                        if (is_dig) begin
                            s.mode  = MODE_INT;
                            s.start = i_state.cursor;
                            s.count = LENGTH_BITS'(1);
                        end else begin
                            id_v = 1'b1;
                            id_k = K_ERROR;
                        end
                    end
                endcase
            end
        end

        if (s.mode == MODE_IDLE) begin
            s.lit_which = 2'd0;
            s.lit_pos   = 3'd0;
        end
    end

    always_comb begin
        r_fin  = '{kind: fin_k, offset: i_state.start, length: fin_len, last: 1'b0};
        r_id   = '{kind: id_k, offset: i_state.cursor, length: LENGTH_BITS'(1), last: 1'b0};
        r_eof  = '{kind: K_EOF, offset: i_state.cursor, length: '0, last: 1'b0};
        o_res0 = fin_v ? r_fin : (id_v ? r_id : r_eof);
        o_res1 = (fin_v && id_v) ? r_id : r_eof;
        o_res_cnt = 2'(fin_v) + 2'(id_v) + 2'(eof_v);
        o_res0.last = (o_res_cnt == 2'd1);
        o_res1.last = 1'b1;
        o_state = s;
    end

endmodule

// ----- design/jts_outq.sv -----
// ----------------------------------------------------------------------------
// jts_outq
// Shifting token queue; takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
module jts_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_cnt,
    input  jts_pkg::t_result i_res0,
    input  jts_pkg::t_result i_res1,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output jts_pkg::t_result o_res
);
    import jts_pkg::*;

    t_result               r_q [Q_DEPTH];
    t_result               n_q [Q_DEPTH];
    t_result               src [Q_DEPTH];
    logic [Q_CNT_BITS-1:0] r_cnt;
    logic [Q_CNT_BITS-1:0] n_cnt;
    logic [Q_CNT_BITS-1:0] base;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_q[0];
    assign o_room  = (r_cnt <= Q_CNT_BITS'(Q_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - Q_CNT_BITS'(pop);
    assign n_cnt   = base + Q_CNT_BITS'(i_push_cnt);

    always_comb begin
        for (int i = 0; i < Q_DEPTH - 1; i++) begin
            src[i] = pop ? r_q[i+1] : r_q[i];
        end
        src[Q_DEPTH-1] = r_q[Q_DEPTH-1];
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (Q_CNT_BITS'(i) < base) begin
                n_q[i] = src[i];
            end else if (Q_CNT_BITS'(i) == base && i_push_cnt != 2'd0) begin
                n_q[i] = i_res0;
            end else if (Q_CNT_BITS'(i) == base + Q_CNT_BITS'(1) && i_push_cnt == 2'd2) begin
                n_q[i] = i_res1;
            end else begin
                n_q[i] = r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

// ----- design/json_token_scanner.sv -----
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON lexer: one byte per word in, zero, one or two tokens per word out.
// ----------------------------------------------------------------------------
// Each input word is a text byte or an end-of-input mark. A word is registered,
// then combinational scan logic updates the lexer state and pushes zero, one or
// two tokens into a four-entry output queue whose head drives the output port.
// Input accepts one word per cycle while the queue holds two tokens or fewer,
// so a text whose bytes give at most one token each streams at one byte per
// cycle when the output is drained every cycle; a byte that closes a number and
// also forms a token of its own puts two tokens in the queue. A token reaches
// the output after its closing byte passes the input register and the queue.
// Offsets wrap at OFFSET_BITS, lengths saturate at LENGTH_BITS, and after end
// of input every word gives one EOF token.
module json_token_scanner (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_byte_in,
    input  logic                            i_end_of_input,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [3:0]                      o_token_kind,
    output logic [jts_pkg::OFFSET_BITS-1:0] o_token_offset,
    output logic [jts_pkg::LENGTH_BITS-1:0] o_token_length,
    output logic                            o_last_of_run
);
    import jts_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_eoi;
    t_state     r_state;
    t_state     n_state;
    t_result    res0;
    t_result    res1;
    t_result    head;
    logic [1:0] res_cnt;
    logic       room;
    logic       adv;

    assign adv        = r_in_valid && room;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_byte_in;
            r_eoi  <= i_end_of_input;
        end
    end

    jts_step u_step (
        .i_state   (r_state),
        .i_byte    (r_byte),
        .i_eoi     (r_eoi),
        .o_state   (n_state),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_res_cnt (res_cnt)
    );

    jts_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (adv ? res_cnt : 2'd0),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_room     (room),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (head)
    );

    assign o_token_kind   = head.kind;
    assign o_token_offset = head.offset;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

endmodule
